// ===== hdl/fci_pkg.sv =====
// ----------------------------------------------------------------------------
// fci_pkg
// shared constants, character codes and helpers for the focuser command
// interpreter
// ----------------------------------------------------------------------------
package fci_pkg;

    localparam int FRAME_LEN   = 16;
    localparam int REPLY_MAX   = 9;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 4;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 96;

    localparam logic [IDX_W-1:0] IDX_MAX = 5'd31;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [7:0] CL_FOCUS = 8'h46;  // F
    localparam logic [7:0] CL_GET   = 8'h47;  // G
    localparam logic [7:0] CL_SET   = 8'h53;  // S

    localparam logic [7:0] LT_GO    = 8'h47;  // G
    localparam logic [7:0] LT_QUIT  = 8'h51;  // Q
    localparam logic [7:0] LT_SPEED = 8'h44;  // D
    localparam logic [7:0] LT_HALF  = 8'h48;  // H
    localparam logic [7:0] LT_MOVE  = 8'h49;  // I
    localparam logic [7:0] LT_TGT   = 8'h4e;  // N
    localparam logic [7:0] LT_POS   = 8'h50;  // P
    localparam logic [7:0] LT_TEMP  = 8'h54;  // T
    localparam logic [7:0] LT_VER   = 8'h56;  // V
    localparam logic [7:0] LT_FULL  = 8'h46;  // F

    localparam logic [7:0] SPD_2    = 8'h02;
    localparam logic [7:0] SPD_4    = 8'h04;
    localparam logic [7:0] SPD_8    = 8'h08;
    localparam logic [7:0] SPD_16   = 8'h10;
    localparam logic [7:0] SPD_32   = 8'h20;

    localparam logic [7:0] PER_2    = 8'd250;
    localparam logic [7:0] PER_4    = 8'd125;
    localparam logic [7:0] PER_8    = 8'd63;
    localparam logic [7:0] PER_16   = 8'd32;
    localparam logic [7:0] PER_32   = 8'd16;

    localparam logic [7:0]  HALF_REPLY = 8'hff;
    localparam logic [31:0] VERSION    = 32'h10;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h57 + {4'd0, n};
        end
        return c;
    endfunction

endpackage

// ===== hdl/focuser_command_interpreter.sv =====
// flow: an accepted word is held in the input register, then its first result word
//   is loaded into the result buffer; one input word per cycle while no getter
//   reply is produced and m_tready is high; a getter reply of n characters plus
//   terminator holds the result register until the single reply shift register has sent it
// reset: aresetn synchronous active low clears frame state, stored values
//   and both valid flags
// ----------------------------------------------------------------------------
// focuser_command_interpreter
// parses serial command frames, updates the focuser settings and streams
// hex replies one character per result word
// ----------------------------------------------------------------------------
module focuser_command_interpreter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // rx_byte[7:0], moving[8], temperature_doubled[24:9]
    input  logic [fci_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // reply_char[7:0], target_position[39:8], current_position[71:40],
    // half_step[72], speed_code[80:73], step_period[88:81],
    // start_request[89], stop_request[90]
    output logic [fci_pkg::M_DATA_W-1:0] m_tdata,
    output logic [0:0]                   m_tuser,   // has_char[0]
    output logic                         m_tlast
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_moving_reg;
    logic [15:0] in_temp_reg;

    // frame state
    logic [fci_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]  cls_reg, cls_next;
    logic [7:0]  let_reg, let_next;
    logic [31:0] hv_reg, hv_next;
    logic        seen_reg, seen_next;
    logic        stopped_reg, stopped_next;

    // stored settings
    logic [31:0] target_reg, target_next;
    logic [31:0] current_reg, current_next;
    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  period_reg, period_next;
    logic        mode_reg, mode_next;
    logic        start_reg, start_next;
    logic        stop_reg, stop_next;

    // result buffer
    logic                      out_valid_reg, out_valid_next;
    logic [fci_pkg::CNT_W-1:0] out_left_reg, out_left_next;
    logic                      out_has_reg, out_has_next;
    logic [7:0]                out_chars_reg [fci_pkg::REPLY_MAX];
    logic [7:0]                out_chars_next [fci_pkg::REPLY_MAX];
    logic [31:0] out_target_reg, out_current_reg;
    logic [7:0]  out_speed_reg, out_period_reg;
    logic        out_mode_reg, out_start_reg, out_stop_reg;

    logic load;
    logic out_done;
    logic s_accept;

    // processing signals
    logic                      clr;
    logic [fci_pkg::IDX_W-1:0] pos;
    logic [7:0]                cls_w, let_w;
    logic [31:0]               hv_w;
    logic                      seen_w, stopped_w;
    fci_pkg::hex_digit_t       dig;
    logic                      is_get;
    logic [31:0]               gval;
    logic                      gknown;
    logic                      gfull;
    logic [fci_pkg::CNT_W-1:0] ndig;
    logic [fci_pkg::CNT_W-1:0] nchars;
    logic [35:0]               gshift;
    logic [7:0]                reply [fci_pkg::REPLY_MAX];

    assign out_done = out_valid_reg && m_tready && (out_left_reg == fci_pkg::CNT_W'(1));
    assign load     = in_valid_reg && (!out_valid_reg || out_done);
    assign s_tready = !in_valid_reg || load;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = (out_left_reg == fci_pkg::CNT_W'(1));
    assign m_tuser[0] = out_has_reg;
    assign m_tdata    = {5'd0, out_stop_reg, out_start_reg, out_period_reg, out_speed_reg,
                         out_mode_reg, out_current_reg, out_target_reg, out_chars_reg[0]};

    // frame parsing and command execution
    always_comb begin
        clr       = (in_char_reg == fci_pkg::CH_COLON);
        pos       = clr ? '0 : idx_reg;
        cls_w     = clr ? 8'd0 : cls_reg;
        let_w     = clr ? 8'd0 : let_reg;
        hv_w      = clr ? 32'd0 : hv_reg;
        seen_w    = clr ? 1'b0 : seen_reg;
        stopped_w = clr ? 1'b0 : stopped_reg;
        dig       = fci_pkg::hex_decode(in_char_reg);

        if (pos == fci_pkg::IDX_W'(1)) begin
            cls_w = in_char_reg;
        end else if (pos == fci_pkg::IDX_W'(2)) begin
            let_w = in_char_reg;
        end else if (pos >= fci_pkg::IDX_W'(3)
                     && {1'b0, pos} < 6'(fci_pkg::FRAME_LEN) && !stopped_w) begin
            if (dig.valid) begin
                hv_w   = {hv_w[27:0], dig.value};
                seen_w = 1'b1;
            end else begin
                stopped_w = 1'b1;
            end
        end
        if ({1'b0, pos} + 6'd1 >= 6'(fci_pkg::FRAME_LEN)) begin
            stopped_w = 1'b1;
        end

        target_next  = target_reg;
        current_next = current_reg;
        speed_next   = speed_reg;
        period_next  = period_reg;
        mode_next    = mode_reg;
        start_next   = start_reg;
        stop_next    = stop_reg;
        is_get       = 1'b0;
        gval         = 32'd0;
        gknown       = 1'b1;
        gfull        = 1'b0;

        if (in_char_reg == fci_pkg::CH_HASH) begin
            if (cls_w == fci_pkg::CL_FOCUS) begin
                if (let_w == fci_pkg::LT_GO) begin
                    start_next = 1'b1;
                    stop_next  = 1'b0;
                end else if (let_w == fci_pkg::LT_QUIT) begin
                    start_next = 1'b0;
                    stop_next  = 1'b1;
                end
            end else if (cls_w == fci_pkg::CL_GET) begin
                is_get = 1'b1;
                case (let_w)
                    fci_pkg::LT_SPEED: gval = {24'd0, speed_reg};
                    fci_pkg::LT_HALF:  gval = mode_reg ? {24'd0, fci_pkg::HALF_REPLY} : 32'd0;
                    fci_pkg::LT_MOVE:  gval = {31'd0, in_moving_reg};
                    fci_pkg::LT_TGT:   gval = target_reg;
                    fci_pkg::LT_POS:   gval = current_reg;
                    fci_pkg::LT_TEMP: begin
                        gval  = {{16{in_temp_reg[15]}}, in_temp_reg};
                        gfull = 1'b1;
                    end
                    fci_pkg::LT_VER:   gval = fci_pkg::VERSION;
                    default:           gknown = 1'b0;
                endcase
            end else if (cls_w == fci_pkg::CL_SET) begin
                if (let_w == fci_pkg::LT_FULL) begin
                    mode_next = 1'b0;
                end else if (let_w == fci_pkg::LT_HALF) begin
                    mode_next = 1'b1;
                end else if (seen_w) begin
                    if (let_w == fci_pkg::LT_TGT) begin
                        target_next = hv_w;
                    end else if (let_w == fci_pkg::LT_POS) begin
                        current_next = hv_w;
                    end else if (let_w == fci_pkg::LT_SPEED) begin
                        speed_next = hv_w[7:0];
                        case (hv_w[7:0])
                            fci_pkg::SPD_2:  period_next = fci_pkg::PER_2;
                            fci_pkg::SPD_4:  period_next = fci_pkg::PER_4;
                            fci_pkg::SPD_8:  period_next = fci_pkg::PER_8;
                            fci_pkg::SPD_16: period_next = fci_pkg::PER_16;
                            fci_pkg::SPD_32: period_next = fci_pkg::PER_32;
                            default:         period_next = period_reg;
                        endcase
                    end
                end
            end
            idx_next     = '0;
            cls_next     = 8'd0;
            let_next     = 8'd0;
            hv_next      = 32'd0;
            seen_next    = 1'b0;
            stopped_next = 1'b0;
        end else begin
            idx_next     = (pos < fci_pkg::IDX_MAX) ? pos + fci_pkg::IDX_W'(1) : fci_pkg::IDX_MAX;
            cls_next     = cls_w;
            let_next     = let_w;
            hv_next      = hv_w;
            seen_next    = seen_w;
            stopped_next = stopped_w;
        end

        // digit count, then left-align the value so digits come out msb first
        ndig = fci_pkg::CNT_W'(1);
        for (int i = 1; i < 8; i++) begin
            if (gval[4*i +: 4] != 4'd0) begin
                ndig = fci_pkg::CNT_W'(i + 1);
            end
        end
        if (gfull) begin
            ndig = fci_pkg::CNT_W'(8);
        end
        if (!gknown) begin
            ndig = '0;
        end
        gshift = {gval, 4'd0} << {fci_pkg::CNT_W'(8) - ndig, 2'b00};
        nchars = ndig + fci_pkg::CNT_W'(1);
        for (int k = 0; k < fci_pkg::REPLY_MAX; k++) begin
            if (!is_get) begin
                reply[k] = 8'd0;
            end else if (fci_pkg::CNT_W'(k) < ndig) begin
                reply[k] = fci_pkg::hex_char(gshift[35-4*k -: 4]);
            end else if (fci_pkg::CNT_W'(k) == ndig) begin
                reply[k] = fci_pkg::CH_HASH;
            end else begin
                reply[k] = 8'd0;
            end
        end
    end

    // result buffer control
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_left_next  = out_left_reg;
        out_has_next   = out_has_reg;
        for (int k = 0; k < fci_pkg::REPLY_MAX; k++) begin
            out_chars_next[k] = out_chars_reg[k];
        end

        if (load) begin
            in_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_has_next   = is_get;
            out_left_next  = is_get ? nchars : fci_pkg::CNT_W'(1);
            for (int k = 0; k < fci_pkg::REPLY_MAX; k++) begin
                out_chars_next[k] = reply[k];
            end
        end else if (out_done) begin
            out_valid_next = 1'b0;
        end else if (out_valid_reg && m_tready) begin
            out_left_next = out_left_reg - fci_pkg::CNT_W'(1);
            for (int k = 0; k < fci_pkg::REPLY_MAX - 1; k++) begin
                out_chars_next[k] = out_chars_reg[k+1];
            end
            out_chars_next[fci_pkg::REPLY_MAX-1] = 8'd0;
        end
        if (s_accept) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
            idx_reg       <= '0;
            cls_reg       <= 8'd0;
            let_reg       <= 8'd0;
            hv_reg        <= 32'd0;
            seen_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
            target_reg    <= 32'd0;
            current_reg   <= 32'd0;
            speed_reg     <= 8'd0;
            period_reg    <= 8'd0;
            mode_reg      <= 1'b0;
            start_reg     <= 1'b0;
            stop_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            out_left_reg  <= out_left_next;
            if (load) begin
                idx_reg     <= idx_next;
                cls_reg     <= cls_next;
                let_reg     <= let_next;
                hv_reg      <= hv_next;
                seen_reg    <= seen_next;
                stopped_reg <= stopped_next;
                target_reg  <= target_next;
                current_reg <= current_next;
                speed_reg   <= speed_next;
                period_reg  <= period_next;
                mode_reg    <= mode_next;
                start_reg   <= start_next;
                stop_reg    <= stop_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg   <= s_tdata[7:0];
            in_moving_reg <= s_tdata[8];
            in_temp_reg   <= s_tdata[24:9];
        end
        out_has_reg <= out_has_next;
        for (int k = 0; k < fci_pkg::REPLY_MAX; k++) begin
            out_chars_reg[k] <= out_chars_next[k];
        end
        if (load) begin
            out_target_reg  <= target_next;
            out_current_reg <= current_next;
            out_speed_reg   <= speed_next;
            out_period_reg  <= period_next;
            out_mode_reg    <= mode_next;
            out_start_reg   <= start_next;
            out_stop_reg    <= stop_next;
        end
    end

endmodule
